// ----- design/prle_pkg.sv -----
// Shared types and constants for the pixel run-length encoder.
package prle_pkg;

	localparam int unsigned PRLE_QUEUE_DEPTH = 4;

	localparam logic [7:0] COUNT_MAX   = 8'hFF;
	localparam logic [7:0] SINGLE_FLAG = 8'h80;

	// one queue entry: the bytes one pixel produced, oldest in slot 0
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} entry_t;

endpackage

// ----- design/prle_front.sv -----
// Front end: takes pixels, updates the run state and packs the bytes each pixel produces.
module prle_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  logic [15:0]      pixel,
	input  logic             block_end,
	input  logic             q_full,
	output logic             q_push,
	output prle_pkg::entry_t q_entry
);
	import prle_pkg::*;

	logic [5:0]      run_colour_q;
	logic [7:0]      run_length_q;
	logic [5:0]      colour;
	logic [5:0]      colour_nx;
	logic [7:0]      len_base;
	logic [7:0]      len_nx;
	logic [1:0]      n;
	logic [2:0][7:0] bytes;
	logic            accept;

	function automatic logic [2:0][7:0] put_byte(logic [2:0][7:0] v, logic [1:0] idx,
		logic [7:0] x);
		logic [2:0][7:0] r;
		r = v;
		unique case (idx)
			2'd0: r[0] = x;
			2'd1: r[1] = x;
			2'd2: r[2] = x;
			default: ;
		endcase
		return r;
	endfunction

	assign colour    = {pixel[14:13], pixel[9:8], pixel[4:3]};
	assign pix_stall = q_full;
	assign accept    = pix_valid && !q_full;

	always_comb begin
		n         = 2'd0;
		bytes     = '0;
		len_base  = run_length_q;
		colour_nx = run_colour_q;
		len_nx    = run_length_q;
		// full run goes out before this pixel is looked at
		if (run_length_q == COUNT_MAX) begin
			bytes    = put_byte(bytes, n, {2'b00, run_colour_q});
			n        = n + 2'd1;
			bytes    = put_byte(bytes, n, COUNT_MAX);
			n        = n + 2'd1;
			len_base = 8'd0;
		end
		if (colour == run_colour_q) begin
			len_nx = len_base + 8'd1;
		end else begin
			if (len_base == 8'd1) begin
				bytes = put_byte(bytes, n, {2'b00, run_colour_q} | SINGLE_FLAG);
				n     = n + 2'd1;
			end else if (len_base != 8'd0) begin
				bytes = put_byte(bytes, n, {2'b00, run_colour_q});
				n     = n + 2'd1;
				bytes = put_byte(bytes, n, len_base);
				n     = n + 2'd1;
			end
			colour_nx = colour;
			len_nx    = 8'd1;
		end
		if (block_end) begin
			// flush: open run is at least one pixel here
			if (len_nx == 8'd1) begin
				bytes = put_byte(bytes, n, {2'b00, colour_nx} | SINGLE_FLAG);
				n     = n + 2'd1;
			end else begin
				bytes = put_byte(bytes, n, {2'b00, colour_nx});
				n     = n + 2'd1;
				bytes = put_byte(bytes, n, len_nx);
				n     = n + 2'd1;
			end
			colour_nx = 6'd0;
			len_nx    = 8'd0;
		end
	end

	assign q_push        = accept && (n != 2'd0);
	assign q_entry.cnt   = n;
	assign q_entry.last  = block_end;
	assign q_entry.bytes = bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_colour_q <= '0;
			run_length_q <= '0;
		end else if (accept) begin
			run_colour_q <= colour_nx;
			run_length_q <= len_nx;
		end
	end

endmodule

// ----- design/prle_fifo.sv -----
// Entry queue between the front end and the byte emitter.
module prle_fifo #(
	parameter int unsigned DEPTH = prle_pkg::PRLE_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  prle_pkg::entry_t wr_entry,
	input  logic             pop,
	output prle_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);
	import prle_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/prle_back.sv -----
// Back end: walks the bytes of each queue entry into a registered output.
module prle_back (
	input  logic             clk,
	input  logic             arst_n,
	input  prle_pkg::entry_t head,
	input  logic             head_valid,
	output logic             q_pop,
	output logic             code_valid,
	input  logic             code_stall,
	output logic [7:0]       code_byte,
	output logic             last_byte
);
	import prle_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] code_byte_q;
	logic       last_byte_q;
	logic       load;
	logic       at_end;
	logic [7:0] sel_byte;

	assign load   = head_valid && (!out_valid_q || !code_stall);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign q_pop  = load && at_end;

	always_comb begin
		unique case (idx_q)
			2'd1:    sel_byte = head.bytes[1];
			2'd2:    sel_byte = head.bytes[2];
			default: sel_byte = head.bytes[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!code_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_byte_q <= sel_byte;
			last_byte_q <= head.last && at_end;
		end
	end

	assign code_valid = out_valid_q;
	assign code_byte  = code_byte_q;
	assign last_byte  = last_byte_q;

endmodule

// ----- design/pixel_run_length_encoder_core.sv -----
// Top level of the pixel run-length encoder.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  pixel   | in        | pix_valid / pix_stall  | pixel, block_end
//  code    | out       | code_valid / code_stall| code_byte, last_byte
//
// A pixel is taken every cycle while the entry queue has room; the run state
// updates in the front end. Bytes leave at one per cycle from the output register
// while code_stall is low; a three-byte pixel holds the emitter until all have
// left. Bytes pass the queue entry and output registers. Reset empties the queue
// and clears the run state. Output stall backs up through the queue to pix_stall.
module pixel_run_length_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = prle_pkg::PRLE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [15:0] pixel,
	input  logic        block_end,
	output logic        code_valid,
	input  logic        code_stall,
	output logic [7:0]  code_byte,
	output logic        last_byte
);
	import prle_pkg::*;

	entry_t push_entry;
	entry_t head_entry;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;

	prle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel     (pixel),
		.block_end (block_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	prle_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	prle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_entry),
		.head_valid (!q_empty),
		.q_pop      (q_pop),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_byte  (code_byte),
		.last_byte  (last_byte)
	);

endmodule

// ----- design/prle_checker.sv -----
// Port-level checks for the pixel run-length encoder, bound to the top level.
module prle_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_stall,
	input logic        block_end,
	input logic        code_valid,
	input logic        code_stall,
	input logic [7:0]  code_byte,
	input logic        last_byte
);

	logic [15:0] open_blocks_q;
	logic        end_in;
	logic        end_out;

	assign end_in  = pix_valid && !pix_stall && block_end;
	assign end_out = code_valid && !code_stall && last_byte;

	// blocks whose end pixel went in but whose last byte has not gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_blocks_q <= '0;
		end else begin
			unique case ({end_in, end_out})
				2'b10:   open_blocks_q <= open_blocks_q + 16'd1;
				2'b01:   open_blocks_q <= open_blocks_q - 16'd1;
				default: open_blocks_q <= open_blocks_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code_byte) && $stable(last_byte))
		else $error("output changed while stalled");

	a_last_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		end_out |-> open_blocks_q != 16'd0)
		else $error("block end byte without a block end pixel");

	// a plain colour byte is always followed by its count, so it is never last
	a_last_not_colour: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && last_byte && !code_byte[7] |-> code_byte >= 8'd2)
		else $error("last byte is an unpaired colour byte");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(code_valid) |-> $past(arst_n))
		else $error("output valid straight out of reset");

endmodule

bind pixel_run_length_encoder_core prle_port_checks u_prle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_stall  (pix_stall),
	.block_end  (block_end),
	.code_valid (code_valid),
	.code_stall (code_stall),
	.code_byte  (code_byte),
	.last_byte  (last_byte)
);

// ----- sim/prle_checker.sv -----
// Checker for the pixel run-length encoder: predicts code bytes and compares transfers.
`timescale 1ns / 1ps

module prle_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  logic              pix_stall,
	input  logic [15:0]       pixel,
	input  logic              block_end,
	input  logic              code_valid,
	input  logic              code_stall,
	input  logic [7:0]        code_byte,
	input  logic              last_byte,
	output int unsigned       fail_count,
	output int unsigned       pending
);
	import prle_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} code_t;

	logic [5:0]  cur_colour;
	logic [7:0]  cur_len;
	logic [7:0]  step_bytes[$];
	code_t       expected_codes[$];
	code_t       want;
	int unsigned errors = 0;
	int unsigned waiting = 0;

	assign fail_count = errors;
	assign pending    = waiting;

	// pixel bits 14:13, 9:8, 4:3 as colour bits: red 5:4, green 3:2, blue 1:0
	function automatic logic [5:0] colour_of(input logic [15:0] p);
		return {p[14:13], p[9:8], p[4:3]};
	endfunction

	function automatic void close_run();
		if (cur_len == 8'd1) begin
			step_bytes.push_back(SINGLE_FLAG | {2'b00, cur_colour});
		end else if (cur_len > 8'd1) begin
			step_bytes.push_back({2'b00, cur_colour});
			step_bytes.push_back(cur_len);
		end
	endfunction

	function automatic void encode_pixel(input logic [15:0] p, input logic last_pix);
		logic [5:0] c;
		int         n;
		c = colour_of(p);
		step_bytes.delete();
		// saturated run goes out before the new pixel is counted
		if (cur_len == COUNT_MAX) begin
			step_bytes.push_back({2'b00, cur_colour});
			step_bytes.push_back(COUNT_MAX);
			cur_len = 8'd0;
		end
		if (c == cur_colour) begin
			cur_len = cur_len + 8'd1;
		end else begin
			close_run();
			cur_colour = c;
			cur_len    = 8'd1;
		end
		if (last_pix) begin
			close_run();
			cur_colour = '0;
			cur_len    = '0;
		end
		n = step_bytes.size();
		for (int i = 0; i < n; i++) begin
			expected_codes.push_back(code_t'{step_bytes[i], last_pix && (i == n - 1)});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_colour = '0;
			cur_len    = '0;
			expected_codes.delete();
		end else begin
			if (code_valid && !code_stall) begin
				if (expected_codes.size() == 0) begin
					$display("%0t: unexpected code transfer: byte %02h last %0b",
						$time, code_byte, last_byte);
					errors++;
				end else begin
					want = expected_codes.pop_front();
					if (want.data !== code_byte) begin
						$display("%0t: code_byte mismatch: expected %02h, actual %02h",
							$time, want.data, code_byte);
						errors++;
					end
					if (want.last !== last_byte) begin
						$display("%0t: last_byte mismatch: expected %0b, actual %0b",
							$time, want.last, last_byte);
						errors++;
					end
				end
			end
			if (pix_valid && !pix_stall) begin
				encode_pixel(pixel, block_end);
			end
		end
		waiting = expected_codes.size();
	end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the pixel run-length encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 160;
	localparam int unsigned PHASE_PIXELS = 10;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	logic [15:0] pixel;
	logic        block_end;
	logic        code_valid;
	logic        code_stall;
	logic [7:0]  code_byte;
	logic        last_byte;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned sender_idle_pct = 22;
	int unsigned receiver_stall_pct = 45;
	bit          hold_req = 1'b0;

	pixel_run_length_encoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel     (pixel),
		.block_end (block_end),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_byte (code_byte),
		.last_byte (last_byte)
	);

	prle_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel     (pixel),
		.block_end (block_end),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_byte (code_byte),
		.last_byte (last_byte),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall, plus one long hold-off on request
	initial begin
		code_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   <= 1'b0;
				code_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				code_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
			end
		end
	end

	// random pixel that reduces to the given colour
	function automatic logic [15:0] pixel_of(input logic [5:0] c);
		logic [15:0] p;
		p = 16'($urandom);
		p[14:13] = c[5:4];
		p[9:8]   = c[3:2];
		p[4:3]   = c[1:0];
		return p;
	endfunction

	task automatic send_pixel(input logic [15:0] p, input logic last_pix);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel     <= p;
		block_end <= last_pix;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pixels_sent++;
	endtask

	// a block of a few short runs, with some fully random pixels mixed in
	task automatic send_block();
		int         nruns;
		int         len;
		logic [5:0] c;
		logic       fin;
		nruns = $urandom_range(1, 6);
		for (int r = 0; r < nruns; r++) begin
			c = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom);
			len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			for (int i = 0; i < len; i++) begin
				fin = (r == nruns - 1) && (i == len - 1);
				if ($urandom_range(0, 9) == 0)
					send_pixel(16'($urandom), fin || ($urandom_range(0, 7) == 0));
				else
					send_pixel(pixel_of(c), fin);
			end
		end
	endtask

	// run long enough to saturate the count, then a block end or a colour change
	task automatic send_long_block(input bit end_on_run);
		logic [5:0] c;
		int         len;
		c = 6'($urandom);
		len = $urandom_range(255, 257);
		for (int i = 0; i < len; i++) begin
			send_pixel(pixel_of(c), end_on_run && (i == len - 1));
		end
		if (!end_on_run) begin
			send_pixel(pixel_of(c ^ 6'($urandom_range(1, 63))), 1'b1);
		end
	endtask

	initial begin
		int unsigned phase_start;
		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pixel     <= '0;
		block_end <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first pixel matching the reset colour, then all-ones with the spare bit set
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b1);
		// same colour from different dropped bits
		send_pixel(16'h7FFF, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h6318, 1'b1);
		// run of two, a single, then a single flushed at block end
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'h0007, 1'b0);
		send_pixel(16'h0018, 1'b0);
		send_pixel(16'h0300, 1'b1);
		// one channel at a time
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h6000, 1'b0);
		send_pixel(16'h0300, 1'b0);
		send_pixel(16'h0018, 1'b1);
		// only the dropped channel bits set
		send_pixel(16'h1CE7, 1'b0);
		send_pixel(16'h1CE7, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct    = 22;
					receiver_stall_pct = 45;
				end
				1: begin
					sender_idle_pct    = 45;
					receiver_stall_pct = 22;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 0)
				hold_req <= 1'b1;
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < PHASE_PIXELS) begin
				send_block();
			end
			if (ph == 2) begin
				send_long_block(1'b0);
			end
		end
		pix_valid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
